FILE: rtl/core/pnh_pkg.sv
// Package for the path key normaliser: sequencer states, scan phases,
// character codes, FNV-1a constants and the control/status structs.
// No dependencies.
package pnh_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [7:0]  CASE_GAP  = 8'd32;

  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    PH_START,
    PH_DOT,
    PH_SKIP,
    PH_BODY
  } pnh_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAR0,
    ST_CHAR1,
    ST_END
  } pnh_state_e;

  typedef struct packed {
    logic load;
    logic emit;
    logic emit_sel;
    logic emit_last;
    logic finish;
  } pnh_cmd_t;

  typedef struct packed {
    logic [1:0] dec_n;
    logic       dec_end;
    logic [1:0] n;
    logic       end_of_path;
    logic       out_free;
  } pnh_status_t;

endpackage

FILE: rtl/core/pnh_datapath.sv
// Datapath of the path key normaliser: byte decode, scan state, FNV-1a hash,
// character count and the output register.
// Depends on pnh_pkg.
module pnh_datapath #(
  parameter int MAX_PATH_LEN = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [7:0]        path_byte_i,
  input  logic              end_of_path_i,
  input  pnh_pkg::pnh_cmd_t cmd_i,
  output pnh_pkg::pnh_status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              item_kind_o,
  output logic [7:0]        key_char_o,
  output logic [31:0]       key_hash_o,
  output logic [8:0]        key_length_o,
  output logic              last_of_run_o
);
  import pnh_pkg::*;

  localparam int CntW = $clog2(MAX_PATH_LEN);
  localparam logic [CntW:0] MaxLen = (CntW + 1)'(MAX_PATH_LEN);

  logic               lower_q;
  pnh_phase_e         phase_q, phase_d;
  logic               pend_q, pend_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [31:0]        hash_q, hash_d;
  logic [7:0]         c0_q, c1_q, c0_d, c1_d;
  logic [1:0]         n_q, n_d;
  logic               end_q;

  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic [7:0]         char_q, char_d;
  logic [31:0]        ohash_q, ohash_d;
  logic [8:0]         len_q, len_d;
  logic               last_q, last_d;

  logic               room1, room2, is_sep, run_body;
  logic [7:0]         ch_sel, ch_fold;
  logic [31:0]        hash_mix;
  logic [CntW+8:0]    cnt_ext;

  assign room1  = ({1'b0, cnt_q} + (CntW + 1)'(1)) < MaxLen;
  assign room2  = ({1'b0, cnt_q} + (CntW + 1)'(2)) < MaxLen;
  assign is_sep = (path_byte_i == CHAR_SLASH) || (path_byte_i == CHAR_BSLASH);

  // decode of the offered byte against the current scan state
  always_comb begin
    phase_d  = phase_q;
    pend_d   = pend_q;
    n_d      = 2'd0;
    c0_d     = path_byte_i;
    c1_d     = path_byte_i;
    run_body = 1'b0;
    case (phase_q)
      PH_START: begin
        if (path_byte_i == CHAR_DOT && !end_of_path_i) begin
          phase_d = PH_DOT;
        end else if (is_sep) begin
          phase_d = PH_SKIP;
        end else begin
          phase_d  = PH_BODY;
          run_body = 1'b1;
        end
      end
      PH_DOT: begin
        if (is_sep) begin
          phase_d = PH_SKIP;
        end else begin
          phase_d = PH_BODY;
          c0_d    = CHAR_DOT;
          n_d     = room2 ? 2'd2 : (room1 ? 2'd1 : 2'd0);
        end
      end
      PH_SKIP: begin
        if (!is_sep) begin
          phase_d  = PH_BODY;
          run_body = 1'b1;
        end
      end
      default: begin
        run_body = 1'b1;
      end
    endcase
    if (run_body) begin
      if (is_sep) begin
        pend_d = pend_q | room1;
      end else if (pend_q) begin
        if (room2) begin
          n_d    = 2'd2;
          c0_d   = CHAR_SLASH;
          pend_d = 1'b0;
        end
      end else if (room1) begin
        n_d = 2'd1;
      end
    end
  end

  assign ch_sel  = cmd_i.emit_sel ? c1_q : c0_q;
  assign ch_fold = (lower_q && (ch_sel inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) ?
                   ch_sel + CASE_GAP : ch_sel;
  assign hash_mix = hash_q ^ {24'b0, ch_fold};
  assign cnt_ext  = {9'b0, cnt_q};

  always_comb begin
    hash_d      = hash_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    char_d      = char_q;
    ohash_d     = ohash_q;
    len_d       = len_q;
    last_d      = last_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      hash_d      = hash_mix * FNV_PRIME;
      cnt_d       = cnt_q + CntW'(1);
      out_valid_d = 1'b1;
      kind_d      = KIND_CHAR;
      char_d      = ch_fold;
      ohash_d     = 32'd0;
      len_d       = 9'd0;
      last_d      = cmd_i.emit_last;
    end else if (cmd_i.finish) begin
      hash_d      = FNV_BASIS;
      cnt_d       = '0;
      out_valid_d = 1'b1;
      kind_d      = KIND_END;
      char_d      = 8'd0;
      ohash_d     = hash_q;
      len_d       = cnt_ext[8:0];
      last_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q     <= 1'b1;
      phase_q     <= PH_START;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      hash_q      <= FNV_BASIS;
      n_q         <= 2'd0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lower_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        phase_q <= phase_d;
        pend_q  <= pend_d;
        n_q     <= n_d;
        end_q   <= end_of_path_i;
      end else if (cmd_i.finish) begin
        phase_q <= PH_START;
        pend_q  <= 1'b0;
      end
      cnt_q       <= cnt_d;
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c0_q <= c0_d;
      c1_q <= c1_d;
    end
    kind_q  <= kind_d;
    char_q  <= char_d;
    ohash_q <= ohash_d;
    len_q   <= len_d;
    last_q  <= last_d;
  end

  assign status_o.dec_n       = n_d;
  assign status_o.dec_end     = end_of_path_i;
  assign status_o.n           = n_q;
  assign status_o.end_of_path = end_q;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign item_kind_o   = kind_q;
  assign key_char_o    = char_q;
  assign key_hash_o    = ohash_q;
  assign key_length_o  = len_q;
  assign last_of_run_o = last_q;

endmodule

FILE: rtl/core/pnh_ctrl.sv
// Sequencer of the path key normaliser: takes a beat, then issues up to two
// character results and the end-of-key result. Depends on pnh_pkg.
module pnh_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pnh_pkg::pnh_status_t status_i,
  output pnh_pkg::pnh_cmd_t    cmd_o
);
  import pnh_pkg::*;

  pnh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.dec_n != 2'd0) begin
            state_d = ST_CHAR0;
          end else if (status_i.dec_end) begin
            state_d = ST_END;
          end
        end
      end
      ST_CHAR0: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = 1'b0;
          cmd_o.emit_last = !status_i.end_of_path && (status_i.n == 2'd1);
          if (status_i.n == 2'd2) begin
            state_d = ST_CHAR1;
          end else if (status_i.end_of_path) begin
            state_d = ST_END;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CHAR1: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = 1'b1;
          cmd_o.emit_last = !status_i.end_of_path;
          state_d = status_i.end_of_path ? ST_END : ST_IDLE;
        end
      end
      ST_END: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/path_key_normalise_hash_unit.sv
// Path key normaliser with FNV-1a 32-bit hash: top level.
// Depends on pnh_pkg, pnh_ctrl and pnh_datapath.
//
// Takes a path one byte per beat and streams out its cleaned key, one
// character per beat, then an end beat with the key length and its FNV-1a
// hash. The sequencer takes a beat in its idle state, then issues the results
// it causes one result per cycle through the one hash multiplier, holding
// while the output register is not free (back-pressure on the output); it takes
// no new byte until those results are out. A result waiting in the output
// register does not stop the next byte being taken.
module path_key_normalise_hash_unit #(
  parameter int MAX_PATH_LEN = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // lowercase_enable
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // path_byte
  input  logic        s_axis_tlast_i,   // end_of_path
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // key_char[7:0], key_hash[39:8], key_length[48:40]
  output logic        m_axis_tuser_o,   // item_kind
  output logic        m_axis_tlast_o    // last_of_run
);
  import pnh_pkg::*;

  pnh_cmd_t    cmd;
  pnh_status_t status;
  logic [7:0]  key_char;
  logic [31:0] key_hash;
  logic [8:0]  key_length;

  pnh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pnh_datapath #(
    .MAX_PATH_LEN (MAX_PATH_LEN)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .path_byte_i   (s_axis_tdata_i),
    .end_of_path_i (s_axis_tlast_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .item_kind_o   (m_axis_tuser_o),
    .key_char_o    (key_char),
    .key_hash_o    (key_hash),
    .key_length_o  (key_length),
    .last_of_run_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'b0, key_length, key_hash, key_char};

endmodule

FILE: test/path_key_normalise_hash_unit_tb.sv
// Testbench for path_key_normalise_hash_unit: streams paths in, checks each key beat and
// the end beat (length and FNV-1a hash) against a behavioural predictor.
// Depends on pnh_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module path_key_normalise_hash_unit_tb;
  import pnh_pkg::*;

  localparam int PATH_LEN_MAX = 512;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_BEATS  = 100;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } path_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic [31:0] hash;
    logic [8:0]  len;
    logic        last;
  } key_beat_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_wdata_i     = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'd0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  path_beat_t  path_q[$];
  key_beat_t   key_exp_q[$];
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          err_cnt        = 0;
  int          phase_beats    = 0;
  int          cycle_cnt      = 0;

  // predictor state
  logic        fold_case  = 1'b1;
  pnh_phase_e  scan_ph    = PH_START;
  logic        slash_held = 1'b0;
  int unsigned key_len    = 0;
  logic [31:0] key_hash   = FNV_BASIS;

  path_key_normalise_hash_unit #(
    .MAX_PATH_LEN(PATH_LEN_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void emit_key_char(logic [7:0] c);
    logic [7:0] f;
    f = c;
    if (fold_case && (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) f = c + CASE_GAP;
    key_hash = (key_hash ^ {24'd0, f}) * FNV_PRIME;
    key_len++;
    key_exp_q.push_back('{KIND_CHAR, f, 32'd0, 9'd0, 1'b0});
  endfunction

  function automatic void take_body_byte(logic [7:0] c);
    logic [7:0] b;
    b = (c == CHAR_BSLASH) ? CHAR_SLASH : c;
    if (b == CHAR_SLASH) begin
      if (!slash_held && key_len + 1 < PATH_LEN_MAX) slash_held = 1'b1;
    end else if (slash_held) begin
      if (key_len + 2 < PATH_LEN_MAX) begin
        emit_key_char(CHAR_SLASH);
        emit_key_char(b);
        slash_held = 1'b0;
      end
    end else if (key_len + 1 < PATH_LEN_MAX) begin
      emit_key_char(b);
    end
  endfunction

  function automatic void normalise_path_byte(logic [7:0] c, logic last);
    logic      is_sep;
    int        first;
    key_beat_t tail;
    is_sep = (c == CHAR_SLASH) || (c == CHAR_BSLASH);
    first  = key_exp_q.size();
    case (scan_ph)
      PH_START: begin
        if (c == CHAR_DOT && !last) begin
          scan_ph = PH_DOT;
        end else if (is_sep) begin
          scan_ph = PH_SKIP;
        end else begin
          scan_ph = PH_BODY;
          take_body_byte(c);
        end
      end
      PH_DOT: begin
        if (is_sep) begin
          scan_ph = PH_SKIP;
        end else begin
          scan_ph = PH_BODY;
          take_body_byte(CHAR_DOT);
          take_body_byte(c);
        end
      end
      PH_SKIP: begin
        if (!is_sep) begin
          scan_ph = PH_BODY;
          take_body_byte(c);
        end
      end
      default: take_body_byte(c);
    endcase
    if (last) begin
      key_exp_q.push_back('{KIND_END, 8'd0, key_hash, key_len[8:0], 1'b0});
      scan_ph    = PH_START;
      slash_held = 1'b0;
      key_len    = 0;
      key_hash   = FNV_BASIS;
    end
    if (key_exp_q.size() > first) begin
      tail = key_exp_q.pop_back();
      tail.last = 1'b1;
      key_exp_q.push_back(tail);
    end
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'd0;
      s_axis_tlast_i  <= 1'b0;
    end else begin : drive
      path_beat_t nxt;
      if (s_axis_tvalid_i && s_axis_tready_o) normalise_path_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (path_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = path_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= nxt.b;
          s_axis_tlast_i  <= nxt.last;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin : watch
      key_beat_t got, want;
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '{m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[39:8],
                m_axis_tdata_o[48:40], m_axis_tlast_o};
        if (key_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected key beat: kind %0d char %h hash %h len %0d last %0d",
                     got.kind, got.ch, got.hash, got.len, got.last);
        end else begin
          want = key_exp_q.pop_front();
          if (got.kind !== want.kind || got.ch !== want.ch || got.hash !== want.hash ||
              got.len !== want.len || got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("key beat mismatch: exp kind %0d char %h hash %h len %0d last %0d",
                       want.kind, want.ch, want.hash, want.len, want.last);
              $display("                   got kind %0d char %h hash %h len %0d last %0d",
                       got.kind, got.ch, got.hash, got.len, got.last);
            end
          end
        end
      end
    end
  end

  task automatic push_beat(logic [7:0] b, logic last);
    path_q.push_back('{b, last});
    phase_beats++;
  endtask

  task automatic push_str(string s, logic last);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], last && (i == s.len() - 1));
  endtask

  task automatic push_random_path();
    logic [7:0] bytes_q[$];
    logic [7:0] c;
    int         n_seg;
    if ($urandom_range(0, 9) == 0) begin
      // noise
      repeat ($urandom_range(1, 8)) bytes_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        bytes_q.push_back(CHAR_DOT);
        bytes_q.push_back($urandom_range(0, 1) ? CHAR_SLASH : CHAR_BSLASH);
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2))
          bytes_q.push_back($urandom_range(0, 1) ? CHAR_SLASH : CHAR_BSLASH);
      n_seg = $urandom_range(1, 4);
      for (int s = 0; s < n_seg; s++) begin
        if (s != 0)
          repeat ($urandom_range(1, 2))
            bytes_q.push_back($urandom_range(0, 1) ? CHAR_SLASH : CHAR_BSLASH);
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 9))
            0, 1, 2: c = CHAR_UPPER_A + 8'($urandom_range(0, 25));
            3, 4:    c = CHAR_UPPER_A + CASE_GAP + 8'($urandom_range(0, 25));
            5:       c = 8'h30 + 8'($urandom_range(0, 9));
            6:       c = CHAR_DOT;
            7:       c = $urandom_range(0, 1) ? CHAR_UPPER_A - 8'd1 : CHAR_UPPER_Z + 8'd1;
            default: c = 8'($urandom_range(1, 255));
          endcase
          bytes_q.push_back(c);
        end
      end
      if ($urandom_range(0, 3) == 0)
        bytes_q.push_back($urandom_range(0, 1) ? CHAR_SLASH : CHAR_BSLASH);
    end
    foreach (bytes_q[i]) push_beat(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  task automatic wait_drained();
    while (path_q.size() != 0 || s_axis_tvalid_i || key_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_case_fold(logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    fold_case = v;
  endtask

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed paths
    push_str("./Ab", 1'b1);
    push_str(".\\/X", 1'b1);
    push_str(".", 1'b1);
    push_str(".a", 1'b1);
    push_str("//", 1'b1);
    push_str("a\\\\b/", 1'b1);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h01, 1'b1);
    push_str("Q", 1'b0);
    wait_drained();
    // case folding switched off mid-path
    write_case_fold(1'b0);
    push_str("Z", 1'b1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_case_fold(p % 2 == 0);
      send_idle_pct  = (p == 1) ? 54 : (p == 3) ? 32 : 0;
      recv_stall_pct = (p == 2) ? 54 : (p == 3) ? 32 : 0;
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) push_random_path();
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pnh_pkg.sv
rtl/core/pnh_datapath.sv
rtl/core/pnh_ctrl.sv
rtl/core/path_key_normalise_hash_unit.sv
test/path_key_normalise_hash_unit_tb.sv
